// ===== rtl/edp_pkg.sv =====
// Shared types and operation codes for the edit distance engine.
package edp_pkg;

    typedef enum logic [1:0] {
        OP_REF    = 2'd0,
        OP_QUERY  = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Tokens that travel down the cell chain, one hop per cycle.
    typedef struct packed {
        logic q_valid;  // query byte wavefront
        logic first;    // first query byte of the pair: columns start at j
        logic f_valid;  // finish token collecting the distance
        logic f_use;    // last active cell overrides the carried distance
    } wave_ctl_t;

    localparam int DIST_W = 7;

endpackage

// ===== rtl/edit_distance_engine_unit.sv =====
// Top level of the edit distance engine: request control and systolic cell chain.
//
//  channel | ports                          | direction | handshake
//  --------+--------------------------------+-----------+-----------------
//  input   | s_operation, s_symbol          | in        | s_valid/s_ready
//  result  | m_distance, m_error            | out       | m_valid/m_ready
//
// Reference and query bytes are taken one per cycle; a query byte walks the
// chain of MAX_LEN cells, one cell per cycle, behind the previous one.
// A finish request follows the last query through all MAX_LEN cells, and input
// stalls during that walk.
// A finish is also held while an earlier result waits on m_ready.
// aresetn is synchronous, active low; no clearing pass is needed.
module edit_distance_engine_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [7:0]                    s_symbol,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [edp_pkg::DIST_W-1:0]    m_distance,
    output logic                          m_error
);
    import edp_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic          busy_reg;
    logic          m_valid_reg;
    logic [DIST_W-1:0] m_distance_reg;
    logic          m_error_reg;
    logic [LW-1:0] ref_len_reg;
    logic [LW-1:0] qlen_reg;
    logic          started_reg;
    logic          error_reg;

    logic          accept;
    logic          is_ref;
    logic          is_query;
    logic          is_finish;
    logic          ref_ok;
    logic          query_ok;
    logic          exit_fin;

    wave_ctl_t     ctl    [0:MAX_LEN];
    logic [7:0]    sym    [0:MAX_LEN];
    logic [LW-1:0] left   [0:MAX_LEN];
    logic [LW-1:0] diag   [0:MAX_LEN];
    logic [LW-1:0] carry  [0:MAX_LEN];

    assign is_ref    = (s_operation == OP_REF);
    assign is_query  = (s_operation == OP_QUERY);
    assign is_finish = (s_operation == OP_FINISH);
    assign s_ready   = !busy_reg && !(is_finish && m_valid_reg);
    assign accept    = s_valid && s_ready;
    assign ref_ok    = !error_reg && !started_reg && (ref_len_reg < LW'(MAX_LEN));
    assign query_ok  = !error_reg && (qlen_reg < LW'(MAX_LEN));
    assign exit_fin  = ctl[MAX_LEN].f_valid;

    always_comb begin
        ctl[0].q_valid = accept && is_query && query_ok;
        ctl[0].first   = !started_reg;
        ctl[0].f_valid = accept && is_finish;
        ctl[0].f_use   = started_reg && !error_reg;
        sym[0]         = s_symbol;
        left[0]        = qlen_reg + LW'(1);
        diag[0]        = qlen_reg;
        priority if (error_reg) begin
            carry[0] = '0;
        end else if (started_reg) begin
            carry[0] = qlen_reg;
        end else begin
            carry[0] = ref_len_reg;
        end
    end

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        edp_cell #(
            .DW  (LW),
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .wr_en     (accept && is_ref && ref_ok),
            .wr_idx    (ref_len_reg[IW-1:0]),
            .wr_sym    (s_symbol),
            .ref_len   (ref_len_reg),
            .ctl_in    (ctl[g]),
            .sym_in    (sym[g]),
            .left_in   (left[g]),
            .diag_in   (diag[g]),
            .carry_in  (carry[g]),
            .ctl_out   (ctl[g+1]),
            .sym_out   (sym[g+1]),
            .left_out  (left[g+1]),
            .diag_out  (diag[g+1]),
            .carry_out (carry[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            ref_len_reg <= '0;
            qlen_reg    <= '0;
            started_reg <= 1'b0;
            error_reg   <= 1'b0;
        end else begin
            if (exit_fin) begin
                busy_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
                ref_len_reg <= '0;
                qlen_reg    <= '0;
                started_reg <= 1'b0;
                error_reg   <= 1'b0;
            end else begin
                if (m_valid_reg && m_ready) begin
                    m_valid_reg <= 1'b0;
                end
                if (accept) begin
                    unique case (s_operation)
                        OP_REF: begin
                            if (ref_ok) begin
                                ref_len_reg <= ref_len_reg + LW'(1);
                            end else begin
                                error_reg <= 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            if (query_ok) begin
                                qlen_reg    <= qlen_reg + LW'(1);
                                started_reg <= 1'b1;
                            end else begin
                                error_reg <= 1'b1;
                            end
                        end
                        OP_FINISH: busy_reg <= 1'b1;
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exit_fin) begin
            m_distance_reg <= DIST_W'(carry[MAX_LEN]);
            m_error_reg    <= error_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_distance = m_distance_reg;
    assign m_error    = m_error_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_distance == '0)
        else $error("error result with nonzero distance");

    a_exit_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        exit_fin |-> busy_reg && !m_valid_reg)
        else $error("finish token left chain while result register full or not busy");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        exit_fin |=> ref_len_reg == '0 && qlen_reg == '0 && !started_reg && !error_reg)
        else $error("pair state not cleared after finish");

    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready)
        else $error("request accepted during finish walk");

endmodule

// ===== rtl/edp_cell.sv =====
// One column cell of the edit distance chain: reference byte, DP value, token stage.
module edp_cell #(
    parameter int DW  = 7,
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [IW-1:0]       wr_idx,
    input  logic [7:0]          wr_sym,
    input  logic [DW-1:0]       ref_len,
    input  edp_pkg::wave_ctl_t  ctl_in,
    input  logic [7:0]          sym_in,
    input  logic [DW-1:0]       left_in,
    input  logic [DW-1:0]       diag_in,
    input  logic [DW-1:0]       carry_in,
    output edp_pkg::wave_ctl_t  ctl_out,
    output logic [7:0]          sym_out,
    output logic [DW-1:0]       left_out,
    output logic [DW-1:0]       diag_out,
    output logic [DW-1:0]       carry_out
);
    import edp_pkg::*;

    logic [7:0]    ref_reg;
    logic [DW-1:0] dp_reg;
    logic [DW-1:0] dp_next;
    logic [DW-1:0] diag_reg;
    logic [DW-1:0] above;
    logic [DW-1:0] min_ab;
    logic [DW-1:0] min_all;
    logic [7:0]    sym_reg;
    logic [DW-1:0] carry_reg;
    logic [DW-1:0] carry_next;
    wave_ctl_t     ctl_reg;

    always_comb begin
        above   = ctl_in.first ? DW'(IDX + 1) : dp_reg;
        min_ab  = (diag_in < left_in) ? diag_in : left_in;
        min_all = (min_ab < above) ? min_ab : above;
        if (ref_reg == sym_in) begin
            dp_next = diag_in;
        end else begin
            dp_next = min_all + DW'(1);
        end
        if (ctl_in.f_use && (ref_len == DW'(IDX + 1))) begin
            carry_next = dp_reg;
        end else begin
            carry_next = carry_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_idx == IW'(IDX))) begin
            ref_reg <= wr_sym;
        end
        if (ctl_in.q_valid) begin
            dp_reg   <= dp_next;
            diag_reg <= above;
            sym_reg  <= sym_in;
        end
        if (ctl_in.f_valid) begin
            carry_reg <= carry_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign sym_out   = sym_reg;
    assign left_out  = dp_reg;
    assign diag_out  = diag_reg;
    assign carry_out = carry_reg;

endmodule
